@@ rtl/core/sliding_window_statistics_unit_defines.svh @@
// Assertion macros for the sliding window statistics unit.
`ifndef SLIDING_WINDOW_STATISTICS_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_STATISTICS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SWS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define SWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SWS_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define SWS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

@@ rtl/core/sws_pkg.sv @@
// Shared constants and controller/datapath interface types.
`default_nettype none
package sws_pkg;

  localparam int SAMPLE_BITS_DEF     = 12;
  localparam int MAX_WINDOW_LOG2_DEF = 12;

  localparam int SAMPLE_W    = 12;
  localparam int CFG_W       = 4;
  localparam int DCOUNT_W    = 13;
  localparam int RANGE_W     = 12;
  localparam int VAR_W       = 47;
  localparam int TOTAL_W     = 48;
  localparam int VAR_TOTAL_W = 63;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

  typedef struct packed {
    logic stream_clr;
    logic clr_step;
    logic accept;
    logic enter;
    logic old_rd;
    logic old_wr;
    logic scan_start;
    logic scan_max;
    logic scan_run;
    logic mul;
    logic vcalc;
    logic load_out;
  } sws_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic was_full;
    logic min_hit;
    logic max_hit;
    logic scan_done;
    logic produce;
    logic last;
    logic out_free;
  } sws_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/sws_ctrl.sv @@
// Sequencing state machine for the sliding window statistics unit.
`default_nettype none
module sws_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              cfg_we,
  input  wire sws_pkg::sws_sts_t sts,
  output sws_pkg::sws_cmd_t      cmd,
  output logic                   in_stall
);

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_ENTER    = 4'd2;
  localparam logic [3:0] ST_OLD_RD   = 4'd3;
  localparam logic [3:0] ST_OLD_WR   = 4'd4;
  localparam logic [3:0] ST_MIN_SCAN = 4'd5;
  localparam logic [3:0] ST_MAX_SCAN = 4'd6;
  localparam logic [3:0] ST_MUL      = 4'd7;
  localparam logic [3:0] ST_VCALC    = 4'd8;
  localparam logic [3:0] ST_OUT      = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic       max_pend_r, max_pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      max_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      max_pend_r <= max_pend_nxt;
    end
  end

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    max_pend_nxt = max_pend_r;
    if (cfg_we) begin
      cmd.stream_clr = 1'b1;
      state_nxt      = ST_CLEAR;
    end else begin
      case (state_r)
        ST_CLEAR: begin
          cmd.clr_step = 1'b1;
          if (sts.clr_last) state_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd.accept = 1'b1;
            state_nxt  = ST_ENTER;
          end
        end
        ST_ENTER: begin
          cmd.enter = 1'b1;
          state_nxt = sts.was_full ? ST_OLD_RD : ST_MUL;
        end
        ST_OLD_RD: begin
          cmd.old_rd = 1'b1;
          state_nxt  = ST_OLD_WR;
        end
        ST_OLD_WR: begin
          cmd.old_wr   = 1'b1;
          max_pend_nxt = sts.max_hit;
          if (sts.min_hit) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_MIN_SCAN;
          end else if (sts.max_hit) begin
            cmd.scan_start = 1'b1;
            cmd.scan_max   = 1'b1;
            state_nxt      = ST_MAX_SCAN;
          end else begin
            state_nxt = ST_MUL;
          end
        end
        ST_MIN_SCAN: begin
          cmd.scan_run = 1'b1;
          if (sts.scan_done) begin
            if (max_pend_r) begin
              cmd.scan_start = 1'b1;
              cmd.scan_max   = 1'b1;
              state_nxt      = ST_MAX_SCAN;
            end else begin
              state_nxt = ST_MUL;
            end
          end
        end
        ST_MAX_SCAN: begin
          cmd.scan_run = 1'b1;
          if (sts.scan_done) state_nxt = ST_MUL;
        end
        ST_MUL: begin
          cmd.mul   = 1'b1;
          state_nxt = ST_VCALC;
        end
        ST_VCALC: begin
          cmd.vcalc = 1'b1;
          state_nxt = ST_OUT;
        end
        ST_OUT: begin
          if (!sts.produce) begin
            state_nxt = ST_IDLE;
          end else if (sts.out_free) begin
            cmd.load_out = 1'b1;
            if (sts.last) begin
              cmd.stream_clr = 1'b1;
              state_nxt      = ST_CLEAR;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
        default: state_nxt = ST_CLEAR;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE) || cfg_we;

endmodule
`default_nettype wire

@@ rtl/core/sws_dp.sv @@
// Datapath: sample ring, occurrence count memory, sums, extremes and totals.
`default_nettype none
module sws_dp #(
  parameter int SAMPLE_BITS     = sws_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW_LOG2 = sws_pkg::MAX_WINDOW_LOG2_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sws_pkg::sws_cmd_t                 cmd,
  output sws_pkg::sws_sts_t                      sts,
  input  wire logic [sws_pkg::SAMPLE_W-1:0]      in_sample,
  input  wire logic                              in_last,
  input  wire logic                              cfg_we,
  input  wire logic [sws_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              out_stall,
  output logic                                   out_valid,
  output logic [sws_pkg::DCOUNT_W-1:0]           out_distinct_count,
  output logic [sws_pkg::RANGE_W-1:0]            out_value_range,
  output logic [sws_pkg::VAR_W-1:0]              out_variance_scaled,
  output logic [sws_pkg::TOTAL_W-1:0]            out_distinct_total,
  output logic [sws_pkg::TOTAL_W-1:0]            out_range_total,
  output logic [sws_pkg::VAR_TOTAL_W-1:0]        out_variance_total,
  output logic [sws_pkg::TOTAL_W-1:0]            out_position_count,
  output logic                                   out_last_out
);

  localparam int SB      = SAMPLE_BITS;
  localparam int MW      = MAX_WINDOW_LOG2;
  localparam int CNT_W   = MW + 1;
  localparam int SUM_W   = SB + MW;
  localparam int SQ_W    = 2 * SB + MW;
  localparam int W2      = 2 * SUM_W;
  localparam int LG_W    = $clog2(MW + 1);
  localparam int DEPTH_V = 1 << SB;
  localparam int DEPTH_R = 1 << MW;
  localparam int VW      = sws_pkg::VAR_W;
  localparam int TW      = sws_pkg::TOTAL_W;
  localparam int VTW     = sws_pkg::VAR_TOTAL_W;

  logic [SB-1:0]    ring_mem [DEPTH_R];
  logic [CNT_W-1:0] cnt_mem  [DEPTH_V];

  logic [sws_pkg::CFG_W-1:0] cfg_r;
  logic [LG_W-1:0]           eff_lg;
  logic [MW-1:0]             wmask;
  logic [CNT_W-1:0]          win_n;
  logic [SB-1:0]             x_in;

  logic [SB-1:0]     x_r, ring_q, min_r, max_r, clr_addr_r, scan_addr_r, scan_d_r;
  logic              last_r, was_full_r, full_r, scan_vld_r, scan_max_r, out_valid_r;
  logic [MW-1:0]     slot_r, wp_r;
  logic [2*SB-1:0]   sq_r, oldsq_r;
  logic [CNT_W-1:0]  cnt_q, fill_r, dist_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SQ_W-1:0]   sumsq_r;
  logic [W2-1:0]     prod_r, a_r;
  logic [W2:0]       diff;
  logic              diff_big;
  logic [VW-1:0]     vs_r, vs_sat;
  logic [TW-1:0]     dtot_r, rtot_r, ptot_r;
  logic [VTW-1:0]    vtot_r;
  logic [TW:0]       dtot_sum, rtot_sum, ptot_sum;
  logic [VTW:0]      vtot_sum;
  logic [TW-1:0]     dtot_nxt, rtot_nxt, ptot_nxt;
  logic [VTW-1:0]    vtot_nxt;
  logic [SB-1:0]     range_w;
  logic              cnt_rd_en, cnt_we;
  logic [SB-1:0]     cnt_raddr, cnt_waddr;
  logic [CNT_W-1:0]  cnt_wdata;

  always_comb begin
    if (cfg_r == '0) begin
      eff_lg = LG_W'(1);
    end else if (32'(cfg_r) > MW) begin
      eff_lg = LG_W'(MW);
    end else begin
      eff_lg = LG_W'(cfg_r);
    end
  end

  assign wmask = MW'({MW{1'b1}} >> (MW - 32'(eff_lg)));
  assign win_n = CNT_W'(wmask) + CNT_W'(1);
  assign x_in  = SB'(in_sample);

  // Count memory port selection.
  always_comb begin
    cnt_rd_en = cmd.accept | cmd.old_rd | cmd.scan_run;
    if (cmd.accept) begin
      cnt_raddr = x_in;
    end else if (cmd.old_rd) begin
      cnt_raddr = ring_q;
    end else begin
      cnt_raddr = scan_addr_r;
    end
    cnt_we = cmd.clr_step | cmd.enter | cmd.old_wr;
    if (cmd.clr_step) begin
      cnt_waddr = clr_addr_r;
      cnt_wdata = '0;
    end else if (cmd.enter) begin
      cnt_waddr = x_r;
      cnt_wdata = cnt_q + CNT_W'(1);
    end else begin
      cnt_waddr = ring_q;
      cnt_wdata = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_rd_en) cnt_q <= cnt_mem[cnt_raddr];
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) ring_q <= ring_mem[wp_r & wmask];
    if (cmd.enter) ring_mem[slot_r] <= x_r;
  end

  // Variance difference and saturation.
  assign diff = {1'b0, a_r} - {1'b0, prod_r};
  generate
    if (W2 > VW) begin : g_wide
      assign diff_big = |diff[W2-1:VW];
    end else begin : g_narrow
      assign diff_big = 1'b0;
    end
  endgenerate
  assign vs_sat = (diff[W2] || diff_big) ? {VW{1'b1}} : VW'(diff[W2-1:0]);

  assign range_w  = max_r - min_r;
  assign dtot_sum = {1'b0, dtot_r} + (TW + 1)'(dist_r);
  assign rtot_sum = {1'b0, rtot_r} + (TW + 1)'(range_w);
  assign vtot_sum = {1'b0, vtot_r} + (VTW + 1)'(vs_r);
  assign ptot_sum = {1'b0, ptot_r} + (TW + 1)'(1);
  assign dtot_nxt = dtot_sum[TW] ? {TW{1'b1}} : dtot_sum[TW-1:0];
  assign rtot_nxt = rtot_sum[TW] ? {TW{1'b1}} : rtot_sum[TW-1:0];
  assign vtot_nxt = vtot_sum[VTW] ? {VTW{1'b1}} : vtot_sum[VTW-1:0];
  assign ptot_nxt = ptot_sum[TW] ? {TW{1'b1}} : ptot_sum[TW-1:0];

  // Stream state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= sws_pkg::CFG_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      dist_r      <= '0;
      dtot_r      <= '0;
      rtot_r      <= '0;
      vtot_r      <= '0;
      ptot_r      <= '0;
      clr_addr_r  <= '0;
      scan_vld_r  <= 1'b0;
      scan_max_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_r <= cfg_data;
      if (cmd.stream_clr) begin
        wp_r       <= '0;
        fill_r     <= '0;
        sum_r      <= '0;
        sumsq_r    <= '0;
        min_r      <= '1;
        max_r      <= '0;
        dist_r     <= '0;
        dtot_r     <= '0;
        rtot_r     <= '0;
        vtot_r     <= '0;
        ptot_r     <= '0;
        clr_addr_r <= '0;
      end else begin
        if (cmd.clr_step) clr_addr_r <= clr_addr_r + SB'(1);
        if (cmd.enter) begin
          wp_r    <= (slot_r + MW'(1)) & wmask;
          sum_r   <= sum_r + SUM_W'(x_r);
          sumsq_r <= sumsq_r + SQ_W'(sq_r);
          if (!was_full_r) fill_r <= fill_r + CNT_W'(1);
          if (cnt_q == '0) dist_r <= dist_r + CNT_W'(1);
          if (x_r < min_r) min_r <= x_r;
          if (x_r > max_r) max_r <= x_r;
        end
        if (cmd.old_rd) begin
          sum_r   <= sum_r - SUM_W'(ring_q);
          sumsq_r <= sumsq_r - SQ_W'(oldsq_r);
        end
        if (cmd.old_wr && cnt_q == CNT_W'(1)) dist_r <= dist_r - CNT_W'(1);
        if (cmd.scan_run && sts.scan_done) begin
          if (scan_max_r) begin
            max_r <= scan_d_r;
          end else begin
            min_r <= scan_d_r;
          end
        end
        if (cmd.load_out && full_r) begin
          dtot_r <= dtot_nxt;
          rtot_r <= rtot_nxt;
          vtot_r <= vtot_nxt;
          ptot_r <= ptot_nxt;
        end
      end
      if (cmd.scan_start) begin
        scan_vld_r <= 1'b0;
        scan_max_r <= cmd.scan_max;
      end else if (cmd.scan_run) begin
        scan_vld_r <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-sample working registers and result payload.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r        <= x_in;
      last_r     <= in_last;
      slot_r     <= wp_r & wmask;
      was_full_r <= (fill_r >= win_n);
      sq_r       <= x_in * x_in;
    end
    if (cmd.enter) oldsq_r <= ring_q * ring_q;
    if (cmd.scan_start) begin
      scan_addr_r <= ring_q;
    end else if (cmd.scan_run) begin
      scan_d_r    <= scan_addr_r;
      scan_addr_r <= scan_max_r ? scan_addr_r - SB'(1) : scan_addr_r + SB'(1);
    end
    if (cmd.mul) begin
      prod_r <= W2'(sum_r) * W2'(sum_r);
      a_r    <= W2'(sumsq_r) << eff_lg;
      full_r <= (fill_r >= win_n);
    end
    if (cmd.vcalc) vs_r <= vs_sat;
    if (cmd.load_out) begin
      out_last_out <= last_r;
      if (full_r) begin
        out_distinct_count  <= sws_pkg::DCOUNT_W'(dist_r);
        out_value_range     <= sws_pkg::RANGE_W'(range_w);
        out_variance_scaled <= vs_r;
        out_distinct_total  <= dtot_nxt;
        out_range_total     <= rtot_nxt;
        out_variance_total  <= vtot_nxt;
        out_position_count  <= ptot_nxt;
      end else begin
        out_distinct_count  <= '0;
        out_value_range     <= '0;
        out_variance_scaled <= '0;
        out_distinct_total  <= dtot_r;
        out_range_total     <= rtot_r;
        out_variance_total  <= vtot_r;
        out_position_count  <= ptot_r;
      end
    end
  end

  always_comb begin
    sts.clr_last  = &clr_addr_r;
    sts.was_full  = was_full_r;
    sts.min_hit   = (cnt_q == CNT_W'(1)) && (ring_q == min_r);
    sts.max_hit   = (cnt_q == CNT_W'(1)) && (ring_q == max_r);
    sts.scan_done = scan_vld_r &&
                    ((cnt_q != '0) || (scan_max_r ? (scan_d_r == '0) : (&scan_d_r)));
    sts.produce   = full_r || last_r;
    sts.last      = last_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ rtl/core/sliding_window_statistics_unit.sv @@
// Top level of the sliding window statistics unit.
//
//  Channel | Direction | Handshake        | Beat contents
//  in_     | input     | in_valid/stall   | sample, last
//  out_    | output    | out_valid/stall  | distinct, range, variance, totals, last_out
//  cfg_    | input     | cfg_valid/ready  | window_log2
//
// Before the window is full a sample passes the accept, enter, multiply, variance
// and output states; once it is full, the oldest-sample read and write states come
// after enter. When the oldest sample was the only copy of the minimum or maximum,
// a scan of the occurrence count memory steps through values to the new extreme.
// After reset, a configuration write and a last sample, a clearing pass over all
// 2^SAMPLE_BITS entries of the count memory runs with the input stalled.
// A result beat waits in the output register while out_stall is high.
`default_nettype none
`include "sliding_window_statistics_unit_defines.svh"
module sliding_window_statistics_unit #(
  parameter int SAMPLE_BITS     = sws_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW_LOG2 = sws_pkg::MAX_WINDOW_LOG2_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [sws_pkg::SAMPLE_W-1:0]       in_sample,
  input  wire logic                               in_last,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [sws_pkg::DCOUNT_W-1:0]            out_distinct_count,
  output logic [sws_pkg::RANGE_W-1:0]             out_value_range,
  output logic [sws_pkg::VAR_W-1:0]               out_variance_scaled,
  output logic [sws_pkg::TOTAL_W-1:0]             out_distinct_total,
  output logic [sws_pkg::TOTAL_W-1:0]             out_range_total,
  output logic [sws_pkg::VAR_TOTAL_W-1:0]         out_variance_total,
  output logic [sws_pkg::TOTAL_W-1:0]             out_position_count,
  output logic                                    out_last_out,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [sws_pkg::CFG_W-1:0]          cfg_window_log2
);

  sws_pkg::sws_cmd_t cmd;
  sws_pkg::sws_sts_t sts;
  logic              cfg_we;
  logic              in_acc;
  logic              var_within_total;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .cfg_we   (cfg_we),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  sws_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .MAX_WINDOW_LOG2 (MAX_WINDOW_LOG2)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_sample           (in_sample),
    .in_last             (in_last),
    .cfg_we              (cfg_we),
    .cfg_data            (cfg_window_log2),
    .out_stall           (out_stall),
    .out_valid           (out_valid),
    .out_distinct_count  (out_distinct_count),
    .out_value_range     (out_value_range),
    .out_variance_scaled (out_variance_scaled),
    .out_distinct_total  (out_distinct_total),
    .out_range_total     (out_range_total),
    .out_variance_total  (out_variance_total),
    .out_position_count  (out_position_count),
    .out_last_out        (out_last_out)
  );

  assign in_acc           = in_valid && !in_stall;
  assign var_within_total = ({16'd0, out_variance_scaled} <= out_variance_total);

  `SWS_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_we, in_stall, "input taken after config write")
  `SWS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_acc, in_stall, "back-to-back beat")
  `SWS_ASSERT_IMPL(a_total_bound, clk, rst_n, out_valid, var_within_total, "variance exceeds total")

endmodule
`default_nettype wire

@@ verif/sliding_window_statistics_unit_tb.sv @@
// Self-checking testbench for the sliding window statistics unit.
`default_nettype none
module sliding_window_statistics_unit_tb;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;
  localparam int SETTLE_CYCLES = 4400;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam longint unsigned MASK47 = (64'd1 << 47) - 1;
  localparam longint unsigned MASK48 = (64'd1 << 48) - 1;
  localparam longint unsigned MASK63 = (64'd1 << 63) - 1;

  typedef struct {
    logic [sws_pkg::DCOUNT_W-1:0]    distinct_count;
    logic [sws_pkg::RANGE_W-1:0]     value_range;
    logic [sws_pkg::VAR_W-1:0]       variance_scaled;
    logic [sws_pkg::TOTAL_W-1:0]     distinct_total;
    logic [sws_pkg::TOTAL_W-1:0]     range_total;
    logic [sws_pkg::VAR_TOTAL_W-1:0] variance_total;
    logic [sws_pkg::TOTAL_W-1:0]     position_count;
    logic                            last_out;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [sws_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [sws_pkg::DCOUNT_W-1:0] out_distinct_count;
  logic [sws_pkg::RANGE_W-1:0] out_value_range;
  logic [sws_pkg::VAR_W-1:0] out_variance_scaled;
  logic [sws_pkg::TOTAL_W-1:0] out_distinct_total;
  logic [sws_pkg::TOTAL_W-1:0] out_range_total;
  logic [sws_pkg::VAR_TOTAL_W-1:0] out_variance_total;
  logic [sws_pkg::TOTAL_W-1:0] out_position_count;
  logic out_last_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sws_pkg::CFG_W-1:0] cfg_window_log2 = sws_pkg::CFG_RESET;

  int idle_mode = IDLE_NONE;
  int rx_hold_cycles = 0;
  int error_count = 0;
  int quiet_cycles = 0;
  window_stats_t expected_stats[$];

  // Mirror of the block state.
  logic [sws_pkg::CFG_W-1:0] win_log2_reg;
  logic [sws_pkg::SAMPLE_W-1:0] ring_mem[4096];
  int unsigned occ_count[4096];
  int unsigned wr_ptr, fill_cnt, distinct_now;
  longint unsigned sum_acc, sq_acc, distinct_acc, range_acc, var_acc, pos_acc;
  int unsigned min_now, max_now;

  always #5 clk = ~clk;

  sliding_window_statistics_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_distinct_count(out_distinct_count), .out_value_range(out_value_range),
    .out_variance_scaled(out_variance_scaled), .out_distinct_total(out_distinct_total),
    .out_range_total(out_range_total), .out_variance_total(out_variance_total),
    .out_position_count(out_position_count), .out_last_out(out_last_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_window_log2(cfg_window_log2)
  );

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                              longint unsigned lim);
    if (a > lim) a = lim;
    if (b > lim - a) return lim;
    return a + b;
  endfunction

  function automatic int unsigned eff_log2();
    if (win_log2_reg < 4'd1) return 1;
    if (win_log2_reg > 4'd12) return 12;
    return 32'(win_log2_reg);
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < 4096; i++) begin
      ring_mem[i] = '0;
      occ_count[i] = 0;
    end
    wr_ptr = 0;
    fill_cnt = 0;
    distinct_now = 0;
    sum_acc = 0;
    sq_acc = 0;
    min_now = 4095;
    max_now = 0;
    distinct_acc = 0;
    range_acc = 0;
    var_acc = 0;
    pos_acc = 0;
  endfunction

  function automatic void predict_sample(logic [sws_pkg::SAMPLE_W-1:0] x, logic is_last);
    int unsigned lg, n, slot, old, v, xv;
    bit was_full;
    longint unsigned vs;
    window_stats_t r;
    lg = eff_log2();
    n = 1 << lg;
    xv = 32'(x);
    was_full = fill_cnt >= n;
    slot = wr_ptr & (n - 1);
    old = 32'(ring_mem[slot]);
    ring_mem[slot] = x;
    wr_ptr = (slot + 1) & (n - 1);
    if (occ_count[xv] == 0) distinct_now++;
    occ_count[xv]++;
    if (xv < min_now) min_now = xv;
    if (xv > max_now) max_now = xv;
    sum_acc += 64'(xv);
    sq_acc += 64'(xv) * 64'(xv);
    if (was_full) begin
      sum_acc -= 64'(old);
      sq_acc -= 64'(old) * 64'(old);
      occ_count[old]--;
      if (occ_count[old] == 0) begin
        distinct_now--;
        if (old == min_now) begin
          v = old;
          while (v < 4095 && occ_count[v] == 0) v++;
          min_now = v;
        end
        if (old == max_now) begin
          v = old;
          while (v > 0 && occ_count[v] == 0) v--;
          max_now = v;
        end
      end
    end else begin
      fill_cnt++;
    end
    if (fill_cnt >= n || is_last) begin
      if (fill_cnt >= n) begin
        vs = (sq_acc << lg) - sum_acc * sum_acc;
        if (vs > MASK47) vs = MASK47;
        r.distinct_count = 13'(distinct_now);
        r.value_range = 12'(max_now - min_now);
        r.variance_scaled = 47'(vs);
        distinct_acc = sat_sum(distinct_acc, 64'(distinct_now), MASK48);
        range_acc = sat_sum(range_acc, 64'((max_now - min_now) & 32'hfff), MASK48);
        var_acc = sat_sum(var_acc, vs, MASK63);
        pos_acc = sat_sum(pos_acc, 64'd1, MASK48);
      end else begin
        r.distinct_count = '0;
        r.value_range = '0;
        r.variance_scaled = '0;
      end
      r.distinct_total = 48'(distinct_acc);
      r.range_total = 48'(range_acc);
      r.variance_total = 63'(var_acc);
      r.position_count = 48'(pos_acc);
      r.last_out = is_last;
      expected_stats = {expected_stats, r};
    end
    if (is_last) clear_window();
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Result checker.
  always @(posedge clk) begin
    window_stats_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected result beat", 64'd1, 64'd0);
      end else begin
        e = expected_stats.pop_front();
        if (out_distinct_count !== e.distinct_count)
          report_mismatch("distinct_count", 64'(out_distinct_count), 64'(e.distinct_count));
        if (out_value_range !== e.value_range)
          report_mismatch("value_range", 64'(out_value_range), 64'(e.value_range));
        if (out_variance_scaled !== e.variance_scaled)
          report_mismatch("variance_scaled", 64'(out_variance_scaled),
                          64'(e.variance_scaled));
        if (out_distinct_total !== e.distinct_total)
          report_mismatch("distinct_total", 64'(out_distinct_total), 64'(e.distinct_total));
        if (out_range_total !== e.range_total)
          report_mismatch("range_total", 64'(out_range_total), 64'(e.range_total));
        if (out_variance_total !== e.variance_total)
          report_mismatch("variance_total", 64'(out_variance_total), 64'(e.variance_total));
        if (out_position_count !== e.position_count)
          report_mismatch("position_count", 64'(out_position_count), 64'(e.position_count));
        if (out_last_out !== e.last_out)
          report_mismatch("last_out", 64'(out_last_out), 64'(e.last_out));
      end
    end
  end

  // Receiver stalls, including the long hold-off.
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_stall = 1'b1;
      rx_hold_cycles--;
    end else if (idle_mode == IDLE_RECV) begin
      out_stall = $urandom_range(99) < 72;
    end else if (idle_mode == IDLE_BOTH) begin
      out_stall = $urandom_range(99) < 20;
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_sample(logic [sws_pkg::SAMPLE_W-1:0] x, logic is_last);
    int idle_pct;
    idle_pct = (idle_mode == IDLE_SEND) ? 72 : (idle_mode == IDLE_BOTH) ? 20 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_sample = x;
    in_last = is_last;
    do @(posedge clk); while (in_stall);
    predict_sample(x, is_last);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (expected_stats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window_log2(logic [sws_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_window_log2 = value;
    do @(posedge clk); while (!cfg_ready);
    win_log2_reg = value;
    clear_window();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Extremes at reset window size, with the lone minimum and maximum leaving.
  task automatic test_directed_extremes();
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b0);
    for (int i = 0; i < 14; i++) send_sample(12'd2048, 1'b0);
    send_sample(12'd2048, 1'b0);
    send_sample(12'd1, 1'b0);
    send_sample(12'd4094, 1'b1);
  endtask

  // Streams of three samples and one sample, which end before any window of four or more fills.
  task automatic test_short_streams();
    send_sample(12'd7, 1'b0);
    send_sample(12'd4095, 1'b0);
    send_sample(12'd0, 1'b1);
    send_sample(12'd5, 1'b1);
  endtask

  // Random well-formed streams with occasional early ends.
  task automatic test_random_streams(int item_total);
    int unsigned n, len, span, base;
    int sent;
    sent = 0;
    n = 1 << eff_log2();
    while (sent < item_total) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, n) : n + $urandom_range(3 * n + 8);
      case ($urandom_range(3))
        0: span = 2;
        1: span = 8;
        2: span = 64;
        default: span = 4096;
      endcase
      base = $urandom_range(4096 - span);
      for (int i = 0; i < len; i++) begin
        send_sample(12'(base + $urandom_range(span - 1)),
                    (i == len - 1) && ($urandom_range(9) != 0));
        sent++;
      end
    end
  endtask

  // The receiver holds off while samples keep coming, so the block backs up.
  task automatic test_backpressure();
    rx_hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_sample(12'($urandom_range(4095)), i == 19);
  endtask

  // A long window filled once, with some positions beyond full.
  task automatic test_long_window();
    for (int i = 0; i < 520; i++) send_sample(12'($urandom_range(4095)), i == 519);
  endtask

  initial begin
    win_log2_reg = sws_pkg::CFG_RESET;
    clear_window();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    test_directed_extremes();
    test_short_streams();
    write_window_log2(4'd0);
    test_short_streams();
    idle_mode = IDLE_NONE;
    test_random_streams(150);
    write_window_log2(4'd2);
    idle_mode = IDLE_SEND;
    test_random_streams(150);
    write_window_log2(4'd3);
    idle_mode = IDLE_RECV;
    test_random_streams(150);
    test_backpressure();
    write_window_log2(4'd5);
    idle_mode = IDLE_BOTH;
    test_random_streams(200);
    write_window_log2(4'd1);
    idle_mode = IDLE_NONE;
    test_random_streams(100);
    write_window_log2(4'd15);
    test_short_streams();
    write_window_log2(4'd13);
    test_short_streams();
    write_window_log2(4'd9);
    idle_mode = IDLE_BOTH;
    test_long_window();
    wait_drained();
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
